@@ rtl/core/sha224_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-224 package
// Shared constants, the command bundle and the SHA-2 round functions.
// ----------------------------------------------------------------------------
package sha224_pkg;

  localparam int ROUNDS_DEFAULT = 64;
  localparam int WORD_W         = 32;
  localparam int HASH_WORDS     = 8;
  localparam int DIGEST_WORDS   = 7;
  localparam int BLOCK_WORDS    = 16;
  localparam int NUM_K          = 64;

  localparam logic [3:0] LAST_BLOCK_WORD = 4'(BLOCK_WORDS - 1);
  localparam logic [2:0] LAST_DIGEST_IDX = 3'(DIGEST_WORDS - 1);

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic       store;
    logic       reload;
    logic       load_vars;
    logic       step;
    logic       add;
    logic [2:0] emit_idx;
  } cmd_t;

  localparam word_t INITIAL_HASH [HASH_WORDS] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam word_t ROUND_K [NUM_K] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ rtl/core/sha224_in_if.sv @@
// ----------------------------------------------------------------------------
// SHA-224 message channel
// Carries one padded message word with its block flags per word.
// ----------------------------------------------------------------------------
interface sha224_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        new_message;
  logic        final_block;

  modport source (output valid, output message_word, output new_message,
                  output final_block, input ready);
  modport sink (input valid, input message_word, input new_message,
                input final_block, output ready);
endinterface

@@ rtl/core/sha224_out_if.sv @@
// ----------------------------------------------------------------------------
// SHA-224 digest channel
// Carries one digest word with its position per word.
// ----------------------------------------------------------------------------
interface sha224_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

@@ rtl/core/sha224_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-224 controller
// Counts message words, sequences the rounds, the hash update and the digest.
// ----------------------------------------------------------------------------
module sha224_ctrl
  import sha224_pkg::*;
#(
  parameter int ROUNDS  = ROUNDS_DEFAULT,
  parameter int ROUND_W = $clog2(ROUNDS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_new,
  input  logic               in_final,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cmd_t               cmd,
  output logic [ROUND_W-1:0] rnd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

  logic [1:0] state;
  logic [3:0] count;
  logic [2:0] emit_idx;
  logic       final_flag;
  logic       accept;
  logic       block_done;
  logic [3:0] count_eff;

  assign count_eff  = in_new ? 4'd0 : count;
  assign in_ready   = !rst && ((state == ST_IDLE) ||
                      ((state == ST_EMIT) && !in_new && (count != LAST_BLOCK_WORD)));
  assign accept     = in_valid && in_ready;
  assign block_done = accept && (count_eff == LAST_BLOCK_WORD);
  assign out_valid  = (state == ST_EMIT);

  always_comb begin
    cmd.store     = accept;
    cmd.reload    = accept && in_new;
    cmd.load_vars = block_done;
    cmd.step      = (state == ST_ROUND);
    cmd.add       = (state == ST_ADD);
    cmd.emit_idx  = emit_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= 4'd0;
      rnd        <= '0;
      emit_idx   <= 3'd0;
      final_flag <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_eff + 4'd1;
      end
      case (state)
        ST_IDLE: begin
          if (block_done) begin
            final_flag <= in_final;
            rnd        <= '0;
            state      <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == LAST_ROUND) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          emit_idx <= 3'd0;
          state    <= final_flag ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == LAST_DIGEST_IDX) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/sha224_datapath.sv @@
// ----------------------------------------------------------------------------
// SHA-224 datapath
// Schedule window, one compression round unit and the chaining hash.
// ----------------------------------------------------------------------------
module sha224_datapath
  import sha224_pkg::*;
#(
  parameter int ROUNDS  = ROUNDS_DEFAULT,
  parameter int ROUND_W = $clog2(ROUNDS)
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [ROUND_W-1:0] rnd,
  input  word_t              message_word,
  output word_t              digest_word
);

  word_t window [BLOCK_WORDS];
  word_t vars   [HASH_WORDS];
  word_t hash   [HASH_WORDS];
  word_t sched_next;
  word_t t1;
  word_t t2;
  word_t shift_in;

  assign sched_next = small_sigma1(window[14]) + window[9] +
                      small_sigma0(window[1]) + window[0];
  assign t1 = vars[7] + big_sigma1(vars[4]) + choose(vars[4], vars[5], vars[6]) +
              ROUND_K[rnd] + window[0];
  assign t2 = big_sigma0(vars[0]) + majority(vars[0], vars[1], vars[2]);
  assign shift_in    = cmd.step ? sched_next : message_word;
  assign digest_word = hash[cmd.emit_idx];

  always_ff @(posedge clk) begin
    if (cmd.store || cmd.step) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[BLOCK_WORDS-1] <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        vars[i] <= '0;
      end
    end else if (cmd.load_vars) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        vars[i] <= hash[i];
      end
    end else if (cmd.step) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reload) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash[i] <= INITIAL_HASH[i];
      end
    end else if (cmd.add) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash[i] <= hash[i] + vars[i];
      end
    end
  end

endmodule

@@ rtl/core/sha224_block_compressor.sv @@
// The first digest word is valid after the rounds and the hash update of a final block.
// A block is taken as 16 words, then compressed through 64 rounds and one hash update
// by the single round unit; no message word is taken until compression is done.
// During digest output, words of a continuing block are taken, up to the fifteenth.
// Reset (synchronous) loads the initial hash, clears the word count and idles the controller.
// ----------------------------------------------------------------------------
// SHA-224 block compressor
// Compresses padded 16-word blocks and streams the seven-word digest.
// ----------------------------------------------------------------------------
module sha224_block_compressor
  import sha224_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  sha224_in_if.sink    msg,
  sha224_out_if.source digest
);

  localparam int ROUND_W = $clog2(ROUNDS);

  cmd_t               cmd;
  logic [ROUND_W-1:0] rnd;

  sha224_ctrl #(.ROUNDS(ROUNDS), .ROUND_W(ROUND_W)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg.valid),
    .in_new    (msg.new_message),
    .in_final  (msg.final_block),
    .in_ready  (msg.ready),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .cmd       (cmd),
    .rnd       (rnd)
  );

  sha224_datapath #(.ROUNDS(ROUNDS), .ROUND_W(ROUND_W)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rnd          (rnd),
    .message_word (msg.message_word),
    .digest_word  (digest.digest_word)
  );

  assign digest.word_index = cmd.emit_idx;
  assign digest.last_word  = (cmd.emit_idx == LAST_DIGEST_IDX);

  assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> !(msg.valid && msg.ready && msg.new_message))
    else $error("Hash reload accepted while the digest is being sent.");

  assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word) |=> !digest.valid)
    else $error("Digest output continued past its last word.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(digest.valid) |-> (digest.word_index == 3'd0))
    else $error("Digest did not start at word zero.");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.add) |-> !msg.ready)
    else $error("Message word taken during compression.");

endmodule

@@ dv/sha224_block_compressor_test.sv @@
// ----------------------------------------------------------------------------
// SHA-224 block compressor testbench
// Streams padded message words through the compressor with random gaps on
// both channels and checks every digest word against an in-bench SHA-224
// model. It covers the standard "abc" vector, ignored final flags, a restart
// in mid-block, chained blocks after a final block and a long output stall.
// ----------------------------------------------------------------------------
module sha224_block_compressor_test
  import sha224_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int MIN_WORDS    = 110;
  localparam int MIN_DIGEST   = 21;

  localparam word_t SHA224_IV [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam word_t SHA2_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } digest_entry_t;

  class digest_scoreboard;
    word_t           chain[8];
    word_t           window[16];
    logic [3:0]      word_count;
    digest_entry_t   expected_digest[$];
    int              words_taken;
    int              blocks_done;
    int              digests_predicted;
    int              digests_checked;
    int              errors;

    function new();
      chain = SHA224_IV;
      foreach (window[i]) window[i] = '0;
      word_count        = '0;
      words_taken       = 0;
      blocks_done       = 0;
      digests_predicted = 0;
      digests_checked   = 0;
      errors            = 0;
    endfunction

    function word_t ror(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      word_t sched[64];
      word_t v[8];
      word_t s0;
      word_t s1;
      word_t t1;
      word_t t2;
      for (int r = 0; r < 16; r++) sched[r] = window[r];
      for (int r = 16; r < 64; r++) begin
        s0 = ror(sched[r-15], 7) ^ ror(sched[r-15], 18) ^ (sched[r-15] >> 3);
        s1 = ror(sched[r-2], 17) ^ ror(sched[r-2], 19) ^ (sched[r-2] >> 10);
        sched[r] = sched[r-16] + s0 + sched[r-7] + s1;
      end
      v = chain;
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA2_K[r] + sched[r];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
      blocks_done++;
    endfunction

    function void take_word(word_t w, logic new_message, logic final_block);
      digest_entry_t e;
      words_taken++;
      if (new_message) begin
        chain      = SHA224_IV;
        word_count = '0;
      end
      window[word_count] = w;
      if (word_count != 4'd15) begin
        word_count = word_count + 4'd1;
        return;
      end
      word_count = '0;
      compress_block();
      if (!final_block) return;
      for (int k = 0; k < 7; k++) begin
        e.digest_word = chain[k];
        e.word_index  = 3'(k);
        e.last_word   = (k == 6);
        expected_digest.push_back(e);
      end
      digests_predicted += 7;
    endfunction

    function void check_digest_word(word_t w, logic [2:0] idx, logic last);
      digest_entry_t e;
      if (expected_digest.size() == 0) begin
        $error("unexpected digest word %08h index %0d", w, idx);
        errors++;
        return;
      end
      e = expected_digest.pop_front();
      digests_checked++;
      if (w !== e.digest_word) begin
        $error("digest_word expected %08h actual %08h", e.digest_word, w);
        errors++;
      end
      if (idx !== e.word_index) begin
        $error("word_index expected %0d actual %0d", e.word_index, idx);
        errors++;
      end
      if (last !== e.last_word) begin
        $error("last_word expected %0b actual %0b", e.last_word, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha224_in_if  msg_if ();
  sha224_out_if digest_if ();

  sha224_block_compressor dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .digest (digest_if)
  );

  digest_scoreboard sb = new();

  int  idle_cycles;
  int  words_sent;
  bit  send_burst;
  bit  hold_done;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (msg_if.valid && msg_if.ready)
        sb.take_word(msg_if.message_word, msg_if.new_message, msg_if.final_block);
      if (digest_if.valid && digest_if.ready)
        sb.check_digest_word(digest_if.digest_word, digest_if.word_index,
                             digest_if.last_word);
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_if.valid && msg_if.ready) || (digest_if.valid && digest_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[sha224_block_compressor] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_word(word_t w, logic new_message, logic final_block);
    int gap;
    gap = send_burst ? 0 : pick_gap();
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_if.valid        <= 1'b1;
    msg_if.message_word <= w;
    msg_if.new_message  <= new_message;
    msg_if.final_block  <= final_block;
    do @(posedge clk); while (!msg_if.ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_block(bit first, bit last);
    for (int i = 0; i < 16; i++)
      send_word(pick_word(), first && (i == 0),
                (i == 15) ? last : 1'($urandom_range(0, 1)));
  endtask

  task automatic send_random_traffic();
    int kind;
    int blocks;
    int n;
    while (words_sent < MIN_WORDS || sb.digests_predicted < MIN_DIGEST) begin
      kind       = $urandom_range(0, 9);
      send_burst = ($urandom_range(0, 3) == 0);
      if (kind == 0) begin
        n = $urandom_range(1, 15);
        for (int i = 0; i < n; i++)
          send_word(pick_word(), i == 0, 1'($urandom_range(0, 1)));
      end else if (kind == 1) begin
        send_block(1'b0, 1'($urandom_range(0, 1)));
      end else begin
        blocks = ($urandom_range(0, 4) == 0) ? 2 : 1;
        for (int b = 0; b < blocks; b++)
          send_block(b == 0, b == blocks - 1);
      end
    end
  endtask

  initial begin
    int stall_left;
    int mode_left;
    bit ready_burst;
    digest_if.ready = 1'b0;
    stall_left  = 0;
    mode_left   = 0;
    ready_burst = 1'b0;
    hold_done   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && sb.digests_checked >= 7 && digest_if.valid) begin
        digest_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          ready_burst = ($urandom_range(0, 3) == 0);
          mode_left   = $urandom_range(16, 96);
        end
        mode_left--;
        if (stall_left > 0) begin
          digest_if.ready <= 1'b0;
          stall_left--;
        end else begin
          digest_if.ready <= 1'b1;
          if (!ready_burst && $urandom_range(0, 4) == 0) stall_left = pick_gap();
        end
        @(negedge clk);
      end
    end
  end

  initial begin
    msg_if.valid        = 1'b0;
    msg_if.message_word = '0;
    msg_if.new_message  = 1'b0;
    msg_if.final_block  = 1'b0;
    words_sent = 0;
    send_burst = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The one-block "abc" message, padded.
    send_word(32'h61626380, 1'b1, 1'b0);
    for (int i = 1; i < 15; i++) send_word('0, 1'b0, 1'b1);
    send_word(32'h00000018, 1'b0, 1'b1);
    // A partial block with final flags that must be ignored, then a restart.
    for (int i = 0; i < 5; i++) send_word('1, 1'b0, 1'b1);
    send_word('1, 1'b1, 1'b1);

    send_random_traffic();
    msg_if.valid <= 1'b0;

    while (sb.expected_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d message words, compressed %0d blocks.", sb.words_taken, sb.blocks_done);
    $display("Checked %0d digest words, output hold-off taken: %0b.",
             sb.digests_checked, hold_done);
    if (sb.errors == 0 && sb.expected_digest.size() == 0)
      $display("[sha224_block_compressor] OK");
    else
      $display("[sha224_block_compressor] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sha224_pkg.sv
rtl/core/sha224_in_if.sv
rtl/core/sha224_out_if.sv
rtl/core/sha224_ctrl.sv
rtl/core/sha224_datapath.sv
rtl/core/sha224_block_compressor.sv
dv/sha224_block_compressor_test.sv
